// ===== src/bfscp_pkg.sv =====
// Shared types and constants for the best-fit socket core picker.
// No dependencies; every other file of the block imports this package.
package bfscp_pkg;

  localparam int MASK_W          = 64;
  localparam int MIDX_W          = 6;
  localparam int CPU_W           = 16;
  localparam int SOCK_FIELD_W    = 3;
  localparam int CORE_FIELD_W    = 5;
  localparam int THR_W           = 8;
  localparam int CAP_W           = 16;
  localparam int CFG_IDX_W       = 2;
  localparam int DEF_MAX_SOCKETS = 4;
  localparam int DEF_MAX_CORES   = 16;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [CAP_W-1:0] NO_CAP = 16'hffff;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COUNT_WHOLE = 2'd0,
    REG_TASK_CAP    = 2'd1,
    REG_THREAD_CAP  = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic             count_whole_cores;
    logic [CAP_W-1:0] task_per_core_cap;
    logic [CAP_W-1:0] thread_per_core_cap;
  } cfg_regs_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_COUNT,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SELECT,
    B_CLAIM,
    B_CLEAR,
    B_FINISH
  } back_state_t;

  // Bits of one socket, placed at bit 0.
  function automatic logic [MASK_W-1:0] socket_bits(logic [7:0] nc);
    socket_bits = ~({MASK_W{1'b1}} << nc);
  endfunction

  function automatic logic [MIDX_W:0] popcount(logic [MASK_W-1:0] v);
    logic [MIDX_W:0] sum;
    sum = '0;
    for (int i = 0; i < MASK_W; i++) begin
      sum = sum + {{MIDX_W{1'b0}}, v[i]};
    end
    popcount = sum;
  endfunction

endpackage

// ===== src/bfscp_ifs.sv =====
// Channel interfaces of the socket core picker: item in, result out, config write.
// Depends on bfscp_pkg for field widths.
interface bfscp_in_if;
  import bfscp_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [MASK_W-1:0]       core_mask;
  logic [SOCK_FIELD_W-1:0] socket_count;
  logic [CORE_FIELD_W-1:0] cores_per_socket;
  logic [CPU_W-1:0]        cpus_wanted;
  logic [THR_W-1:0]        node_threads;
  modport source (output valid, core_mask, socket_count, cores_per_socket, cpus_wanted,
                  node_threads, input ready);
  modport sink (input valid, core_mask, socket_count, cores_per_socket, cpus_wanted,
                node_threads, output ready);
endinterface

interface bfscp_out_if;
  import bfscp_pkg::*;
  logic              valid;
  logic              ready;
  logic [MASK_W-1:0] kept_mask;
  logic [CPU_W-1:0]  cpu_count;
  logic              shortage;
  modport source (output valid, kept_mask, cpu_count, shortage, input ready);
  modport sink (input valid, kept_mask, cpu_count, shortage, output ready);
endinterface

interface bfscp_cfg_if;
  import bfscp_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CAP_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== src/best_fit_socket_core_pick.sv =====
// Top level of the best-fit socket core picker: config registers, front end,
// entry queue and back end. Depends on bfscp_pkg, bfscp_ifs, bfscp_front/queue/back.
//
//  channel | dir | transfer when        | payload
//  --------+-----+----------------------+--------------------------------------------
//  item    | in  | item.valid & ready   | core_mask, socket_count, cores_per_socket,
//          |     |                      | cpus_wanted, node_threads
//  result  | out | result.valid & ready | kept_mask, cpu_count, shortage
//  cfg     | in  | cfg.valid & ready    | index (0..2), data; ready is always high
//
// Steps: the front end does one socket popcount per cycle over all MAX_SOCKETS
// sockets, then pushes the entry. The back end loads the entry, walks the
// socket_count sockets in each selection round and the cores of each claimed
// socket, makes a release pass over all MAX_SOCKETS sockets once the need is met
// (or closes with one empty round when cores run short), then drives the result.
// The back end's per-core claim walk sets the throughput.
// Reset (rst, synchronous) clears config registers, queue and all handshake state.
// A stalled result holds in the output register; the queue lets the front end
// accept and count the next item meanwhile.
module best_fit_socket_core_pick #(
  parameter int MAX_SOCKETS          = bfscp_pkg::DEF_MAX_SOCKETS,
  parameter int MAX_CORES_PER_SOCKET = bfscp_pkg::DEF_MAX_CORES
) (
  input  logic        clk,
  input  logic        rst,
  bfscp_in_if.sink    item,
  bfscp_out_if.source result,
  bfscp_cfg_if.sink   cfg
);
  import bfscp_pkg::*;

  localparam int SW      = $clog2(MAX_SOCKETS + 1);
  localparam int CNW     = $clog2(MAX_CORES_PER_SOCKET + 1);
  // Entry: counts, thread limit, node threads, cpus, cores, sockets, mask.
  localparam int ENTRY_W = MAX_SOCKETS * CNW + 2 * THR_W + CPU_W + CNW + SW + MASK_W;

  cfg_regs_t regs;

  logic               push_valid;
  logic               push_ready;
  logic [ENTRY_W-1:0] push_data;
  logic               pop_valid;
  logic               pop_ready;
  logic [ENTRY_W-1:0] pop_data;

  // Config writes are taken in any cycle; index 3 is dropped. Change registers
  // only while no item is in flight.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_COUNT_WHOLE: regs.count_whole_cores   <= cfg.data[0];
        REG_TASK_CAP:    regs.task_per_core_cap   <= cfg.data;
        REG_THREAD_CAP:  regs.thread_per_core_cap <= cfg.data;
        default: ;
      endcase
    end
  end

  // Front: accept the item and count available cores per socket.
  bfscp_front #(
    .MAX_SOCKETS          (MAX_SOCKETS),
    .MAX_CORES_PER_SOCKET (MAX_CORES_PER_SOCKET),
    .ENTRY_W              (ENTRY_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .regs       (regs),
    .item       (item),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // Decouple counting from the selection rounds.
  bfscp_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Back: pick sockets, claim cores, release the rest, drive the result.
  bfscp_back #(
    .MAX_SOCKETS          (MAX_SOCKETS),
    .MAX_CORES_PER_SOCKET (MAX_CORES_PER_SOCKET),
    .ENTRY_W              (ENTRY_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .regs      (regs),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .result    (result)
  );

endmodule

// ===== src/bfscp_front.sv =====
// Front end: accepts a node item, saturates geometry, works out threads per core
// and counts available cores per socket, then pushes the entry. Uses bfscp_pkg.
module bfscp_front #(
  parameter int MAX_SOCKETS          = bfscp_pkg::DEF_MAX_SOCKETS,
  parameter int MAX_CORES_PER_SOCKET = bfscp_pkg::DEF_MAX_CORES,
  parameter int ENTRY_W              = 128
) (
  input  logic                 clk,
  input  logic                 rst,
  input  bfscp_pkg::cfg_regs_t regs,
  bfscp_in_if.sink             item,
  output logic                 push_valid,
  input  logic                 push_ready,
  output logic [ENTRY_W-1:0]   push_data
);
  import bfscp_pkg::*;

  localparam int SW  = $clog2(MAX_SOCKETS + 1);
  localparam int CNW = $clog2(MAX_CORES_PER_SOCKET + 1);
  localparam int SIW = (MAX_SOCKETS > 1) ? $clog2(MAX_SOCKETS) : 1;
  localparam int PW0 = $clog2(MAX_SOCKETS * MAX_CORES_PER_SOCKET + 1);
  localparam int PW  = (PW0 > 7) ? PW0 : 7;

  front_state_t state, state_next;

  logic [MASK_W-1:0]                  mask;
  logic [SW-1:0]                      ns;
  logic [CNW-1:0]                     nc;
  logic [CPU_W-1:0]                   cpus;
  logic [THR_W-1:0]                   nt;
  logic [THR_W-1:0]                   vp;
  logic [MAX_SOCKETS-1:0][CNW-1:0]    cnt;
  logic [SIW-1:0]                     s;

  logic [CAP_W-1:0]  cap;
  logic [THR_W-1:0]  vp_calc;
  logic [SW-1:0]     ns_sat;
  logic [CNW-1:0]    nc_sat;
  logic [MASK_W-1:0] slice;

  // Thread limit: least of node threads and each nonzero cap, never zero.
  always_comb begin
    cap = NO_CAP;
    if (regs.task_per_core_cap != '0) begin
      cap = regs.task_per_core_cap;
    end
    if (regs.thread_per_core_cap != '0 && regs.thread_per_core_cap < cap) begin
      cap = regs.thread_per_core_cap;
    end
    vp_calc = (CAP_W'(item.node_threads) < cap) ? item.node_threads : cap[THR_W-1:0];
    if (vp_calc == '0) begin
      vp_calc = THR_W'(1);
    end
  end

  assign ns_sat = (32'(item.socket_count) > MAX_SOCKETS) ? SW'(MAX_SOCKETS)
                                                          : SW'(item.socket_count);
  assign nc_sat = (32'(item.cores_per_socket) > MAX_CORES_PER_SOCKET)
                  ? CNW'(MAX_CORES_PER_SOCKET) : CNW'(item.cores_per_socket);

  assign slice = (mask >> (PW'(s) * PW'(nc))) & socket_bits(8'(nc));

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE:  if (item.valid) state_next = F_COUNT;
      F_COUNT: if (s == SIW'(MAX_SOCKETS - 1)) state_next = F_PUSH;
      F_PUSH:  if (push_ready) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    item.ready = (state == F_IDLE);
    push_valid = (state == F_PUSH);
    push_data  = {cnt, vp, nt, cpus, nc, ns, mask};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      F_IDLE: begin
        if (item.valid) begin
          mask <= item.core_mask;
          ns   <= ns_sat;
          nc   <= nc_sat;
          cpus <= item.cpus_wanted;
          nt   <= item.node_threads;
          vp   <= vp_calc;
          s    <= '0;
        end
      end
      F_COUNT: begin
        cnt[s] <= (32'(s) < 32'(ns)) ? CNW'(popcount(slice)) : '0;
        if (s != SIW'(MAX_SOCKETS - 1)) begin
          s <= s + 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== src/bfscp_queue.sv =====
// Small FIFO between front and back ends of the socket core picker.
// DEPTH must be a power of two, at least 2. Uses bfscp_pkg for the default depth.
module bfscp_queue #(
  parameter int WIDTH = 128,
  parameter int DEPTH = bfscp_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);
  import bfscp_pkg::*;

  localparam int PTRW = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTRW-1:0]  wr_ptr;
  logic [PTRW-1:0]  rd_ptr;
  logic [CW-1:0]    fill;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (fill != CW'(DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== src/bfscp_back.sv =====
// Back end: runs the best-fit socket rounds, claims cores, releases the rest
// and holds the result in an output register. Uses bfscp_pkg and bfscp_out_if.
module bfscp_back #(
  parameter int MAX_SOCKETS          = bfscp_pkg::DEF_MAX_SOCKETS,
  parameter int MAX_CORES_PER_SOCKET = bfscp_pkg::DEF_MAX_CORES,
  parameter int ENTRY_W              = 128
) (
  input  logic                 clk,
  input  logic                 rst,
  input  bfscp_pkg::cfg_regs_t regs,
  input  logic                 pop_valid,
  output logic                 pop_ready,
  input  logic [ENTRY_W-1:0]   pop_data,
  bfscp_out_if.source          result
);
  import bfscp_pkg::*;

  localparam int SW  = $clog2(MAX_SOCKETS + 1);
  localparam int CNW = $clog2(MAX_CORES_PER_SOCKET + 1);
  localparam int SIW = (MAX_SOCKETS > 1) ? $clog2(MAX_SOCKETS) : 1;
  localparam int KIW = (MAX_CORES_PER_SOCKET > 1) ? $clog2(MAX_CORES_PER_SOCKET) : 1;
  localparam int KW  = $clog2(MAX_SOCKETS * MAX_CORES_PER_SOCKET + 1);
  localparam int PW0 = $clog2(MAX_SOCKETS * MAX_CORES_PER_SOCKET + 1);
  localparam int PW  = (PW0 > 7) ? PW0 : 7;

  back_state_t state, state_next;

  // Unpacked queue entry.
  logic [MAX_SOCKETS-1:0][CNW-1:0] q_cnt;
  logic [THR_W-1:0]                q_vp;
  logic [THR_W-1:0]                q_nt;
  logic [CPU_W-1:0]                q_cpus;
  logic [CNW-1:0]                  q_nc;
  logic [SW-1:0]                   q_ns;
  logic [MASK_W-1:0]               q_mask;

  // Working registers.
  logic [MAX_SOCKETS-1:0][CNW-1:0] cnt;
  logic [MAX_SOCKETS-1:0]          used;
  logic [MASK_W-1:0]               mask;
  logic [SW-1:0]                   ns;
  logic [CNW-1:0]                  nc;
  logic [CPU_W-1:0]                cpus;
  logic [CPU_W-1:0]                cpus_in;
  logic [THR_W-1:0]                nt;
  logic [THR_W-1:0]                vp;
  logic [KW-1:0]                   kept;
  logic [SIW-1:0]                  si;
  logic [KIW-1:0]                  k;
  logic [CNW-1:0]                  best;
  logic                            best_ok;
  logic [SIW-1:0]                  loc;

  // Output register.
  logic              oval;
  logic [MASK_W-1:0] out_mask;
  logic [CPU_W-1:0]  out_count;
  logic              out_short;

  // Selection step signals.
  logic [CNW-1:0] c;
  logic           ok;
  logic           upd;
  logic [CNW-1:0] best_nx;
  logic [SIW-1:0] loc_nx;
  logic           ok_nx;

  // Claim step signals.
  logic [PW-1:0]    j;
  logic             bit_on;
  logic [CPU_W-1:0] cpus_dec;
  logic [CPU_W-1:0] cpus_after;

  logic             out_free;
  logic [MASK_W-1:0] clr_bits;

  assign {q_cnt, q_vp, q_nt, q_cpus, q_nc, q_ns, q_mask} = pop_data;

  // A socket is enough when count * threads covers the remaining cpus.
  always_comb begin
    c       = cnt[si];
    ok      = (32'(c) * 32'(vp)) >= 32'(cpus);
    upd     = (best == '0) || (ok && !best_ok) || (ok && c < best) || (!ok && c > best);
    best_nx = upd ? c : best;
    loc_nx  = upd ? si : loc;
    ok_nx   = upd ? ok : best_ok;
  end

  always_comb begin
    j          = PW'(loc) * PW'(nc) + PW'(k);
    bit_on     = (j < PW'(MASK_W)) && mask[j[MIDX_W-1:0]];
    cpus_dec   = (cpus < CPU_W'(vp)) ? '0 : cpus - CPU_W'(vp);
    cpus_after = (cpus != '0 && bit_on) ? cpus_dec : cpus;
  end

  assign clr_bits = socket_bits(8'(nc)) << (PW'(si) * PW'(nc));
  assign out_free = !oval || result.ready;

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (pop_valid) begin
          state_next = (q_cpus == '0 || q_ns == '0) ? B_FINISH : B_SELECT;
        end
      end
      B_SELECT: begin
        if (si == '0) begin
          state_next = (best_nx == '0) ? B_FINISH : B_CLAIM;
        end
      end
      B_CLAIM: begin
        if (k == '0) begin
          state_next = (cpus_after != '0) ? B_SELECT : B_CLEAR;
        end
      end
      B_CLEAR: begin
        if (si == SIW'(MAX_SOCKETS - 1)) state_next = B_FINISH;
      end
      B_FINISH: begin
        if (out_free) state_next = B_IDLE;
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop_ready        = (state == B_IDLE);
    result.valid     = oval;
    result.kept_mask = out_mask;
    result.cpu_count = out_count;
    result.shortage  = out_short;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      oval  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == B_FINISH && out_free) begin
        oval <= 1'b1;
      end else if (result.ready) begin
        oval <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (pop_valid) begin
          cnt     <= q_cnt;
          used    <= '0;
          mask    <= q_mask;
          ns      <= q_ns;
          nc      <= q_nc;
          cpus    <= q_cpus;
          cpus_in <= q_cpus;
          nt      <= q_nt;
          vp      <= q_vp;
          kept    <= '0;
          si      <= SIW'(q_ns - 1'b1);
          best    <= '0;
          best_ok <= 1'b0;
          loc     <= '0;
        end
      end
      B_SELECT: begin
        best    <= best_nx;
        best_ok <= ok_nx;
        loc     <= loc_nx;
        if (si != '0) begin
          si <= si - 1'b1;
        end else if (best_nx != '0) begin
          // A picked socket is drained or ends the item, so its count drops to zero.
          used[loc_nx] <= 1'b1;
          cnt[loc_nx]  <= '0;
          k            <= KIW'(nc - 1'b1);
        end
      end
      B_CLAIM: begin
        if (cpus == '0) begin
          if (j < PW'(MASK_W)) mask[j[MIDX_W-1:0]] <= 1'b0;
        end else if (bit_on) begin
          kept <= kept + 1'b1;
        end
        cpus <= cpus_after;
        if (k != '0) begin
          k <= k - 1'b1;
        end else if (cpus_after != '0) begin
          si      <= SIW'(ns - 1'b1);
          best    <= '0;
          best_ok <= 1'b0;
          loc     <= '0;
        end else begin
          si <= '0;
        end
      end
      B_CLEAR: begin
        if (32'(si) < 32'(ns) && !used[si]) begin
          mask <= mask & ~clr_bits;
        end
        if (si != SIW'(MAX_SOCKETS - 1)) begin
          si <= si + 1'b1;
        end
      end
      B_FINISH: begin
        if (out_free) begin
          out_mask  <= mask;
          out_short <= (cpus != '0);
          out_count <= (regs.count_whole_cores && nt > THR_W'(1))
                       ? CPU_W'(32'(kept) * 32'(nt)) : cpus_in;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== tb/best_fit_socket_core_pick_checker.sv =====
// Scoreboard for the best-fit socket core picker: watches the item, result and
// config channels, predicts each result and compares. Depends on bfscp_pkg, bfscp_ifs.
module best_fit_socket_core_pick_checker
  import bfscp_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  bfscp_in_if   item,
  bfscp_out_if  result,
  bfscp_cfg_if  cfg,
  output int    errors,
  output int    outstanding,
  output int    checked,
  output int    short_seen
);

  typedef struct packed {
    logic [MASK_W-1:0] kept_mask;
    logic [CPU_W-1:0]  cpu_count;
    logic              shortage;
  } pick_result_t;

  typedef struct {
    int           seq;
    pick_result_t res;
  } pending_pick_t;

  // Local copy of the register file.
  logic             whole_cores;
  logic [CAP_W-1:0] task_cap;
  logic [CAP_W-1:0] thread_cap;

  pending_pick_t pick_q[$];
  int            node_seq;
  int            fail_cnt;
  int            check_cnt;
  int            short_cnt;

  function automatic pick_result_t best_fit_claim(
    input logic [MASK_W-1:0]       core_mask,
    input logic [SOCK_FIELD_W-1:0] socket_count,
    input logic [CORE_FIELD_W-1:0] cores_per_socket,
    input logic [CPU_W-1:0]        cpus_wanted,
    input logic [THR_W-1:0]        node_threads
  );
    pick_result_t      r;
    logic [MASK_W-1:0] mask;
    int                ns, nc, left, tpc, cap, need, best, loc, kept, c, j, s, k;
    bit                best_fits, fits;
    int                avail [DEF_MAX_SOCKETS];
    bit                picked [DEF_MAX_SOCKETS];
    mask = core_mask;
    ns   = (socket_count > DEF_MAX_SOCKETS) ? DEF_MAX_SOCKETS : int'(socket_count);
    nc   = (cores_per_socket > DEF_MAX_CORES) ? DEF_MAX_CORES : int'(cores_per_socket);
    cap  = int'(NO_CAP);
    if (task_cap != '0) cap = int'(task_cap);
    if (thread_cap != '0 && int'(thread_cap) < cap) cap = int'(thread_cap);
    tpc = (int'(node_threads) < cap) ? int'(node_threads) : cap;
    if (tpc == 0) tpc = 1;
    kept = 0;
    for (s = 0; s < DEF_MAX_SOCKETS; s++) begin
      avail[s]  = 0;
      picked[s] = 1'b0;
    end
    for (s = 0; s < ns; s++)
      for (k = 0; k < nc; k++)
        if (s * nc + k < MASK_W && mask[s * nc + k]) avail[s]++;
    left = int'(cpus_wanted);
    while (left > 0) begin
      need      = (left + tpc - 1) / tpc;
      best      = 0;
      loc       = 0;
      best_fits = 1'b0;
      // Scan high to low so a tie stays on the higher socket.
      for (s = ns - 1; s >= 0; s--) begin
        c    = avail[s];
        fits = (c >= need);
        if (best == 0 || (fits && !best_fits) || (fits && c < best) ||
            (!fits && c > best)) begin
          best      = c;
          loc       = s;
          best_fits = fits;
        end
      end
      if (best == 0) break;
      picked[loc] = 1'b1;
      for (k = nc - 1; k >= 0; k--) begin
        j = loc * nc + k;
        if (left == 0) begin
          if (j < MASK_W) mask[j] = 1'b0;
        end else if (j < MASK_W && mask[j]) begin
          avail[loc]--;
          kept++;
          left = (left < tpc) ? 0 : left - tpc;
        end
      end
      if (left == 0) begin
        for (s = 0; s < ns; s++)
          if (!picked[s])
            for (k = 0; k < nc; k++)
              if (s * nc + k < MASK_W) mask[s * nc + k] = 1'b0;
      end
    end
    r.kept_mask = mask;
    if (whole_cores && node_threads > 1)
      r.cpu_count = CPU_W'(kept * int'(node_threads));
    else
      r.cpu_count = cpus_wanted;
    r.shortage = (left > 0);
    return r;
  endfunction

  always @(posedge clk) begin
    pending_pick_t want;
    pick_result_t  got;
    if (rst) begin
      whole_cores = 1'b0;
      task_cap    = '0;
      thread_cap  = '0;
      pick_q.delete();
      node_seq  = 0;
      fail_cnt  = 0;
      check_cnt = 0;
      short_cnt = 0;
    end else begin
      // Compare the result transfer first; it can never belong to an item taken now.
      if (result.valid && result.ready) begin
        got.kept_mask = result.kept_mask;
        got.cpu_count = result.cpu_count;
        got.shortage  = result.shortage;
        if (pick_q.size() == 0) begin
          if (fail_cnt < 10)
            $display("[%0t] result with nothing expected: mask %h count %0d short %b",
                     $time, got.kept_mask, got.cpu_count, got.shortage);
          fail_cnt++;
        end else begin
          want = pick_q.pop_front();
          check_cnt++;
          if (got !== want.res) begin
            if (fail_cnt < 10)
              $display("[%0t] node %0d: expected mask %h count %0d short %b, got %h %0d %b",
                       $time, want.seq, want.res.kept_mask, want.res.cpu_count,
                       want.res.shortage, got.kept_mask, got.cpu_count, got.shortage);
            fail_cnt++;
          end
        end
      end
      if (item.valid && item.ready) begin
        want.seq = node_seq++;
        want.res = best_fit_claim(item.core_mask, item.socket_count, item.cores_per_socket,
                                  item.cpus_wanted, item.node_threads);
        if (want.res.shortage) short_cnt++;
        pick_q.push_back(want);
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg_index_t'(cfg.index))
          REG_COUNT_WHOLE: whole_cores = cfg.data[0];
          REG_TASK_CAP:    task_cap    = cfg.data;
          REG_THREAD_CAP:  thread_cap  = cfg.data;
          default: ;
        endcase
      end
    end
    errors      <= fail_cnt;
    outstanding <= pick_q.size();
    checked     <= check_cnt;
    short_seen  <= short_cnt;
  end

endmodule

// ===== tb/best_fit_socket_core_pick_tb.sv =====
// Testbench top for the best-fit socket core picker: clock, reset, stimulus and verdict.
// Depends on bfscp_pkg, bfscp_ifs, the block and best_fit_socket_core_pick_checker.
module best_fit_socket_core_pick_tb;
  import bfscp_pkg::*;

  localparam int CYCLE_LIMIT   = 1_500_000;
  localparam int NUM_SETTINGS  = 9;
  localparam int NODES_PER_SET = 220;
  localparam int LONG_HOLD     = 500;
  localparam int SETTLE_CYCLES = 150;

  typedef struct packed {
    logic [MASK_W-1:0]       core_mask;
    logic [SOCK_FIELD_W-1:0] socket_count;
    logic [CORE_FIELD_W-1:0] cores_per_socket;
    logic [CPU_W-1:0]        cpus_wanted;
    logic [THR_W-1:0]        node_threads;
  } node_item_t;

  typedef struct packed {
    logic             whole_cores;
    logic [CAP_W-1:0] task_cap;
    logic [CAP_W-1:0] thread_cap;
  } reg_setting_t;

  logic clk = 1'b0;
  logic rst;
  int   cycle_count = 0;
  int   hold_asks = 0;  // bumped by stimulus, served by the result side
  bit   quiet = 1'b0;   // no idling on either side once set

  int errors, outstanding, checked, short_seen;

  bfscp_in_if  node_ch ();
  bfscp_out_if pick_ch ();
  bfscp_cfg_if cfg_ch ();

  best_fit_socket_core_pick i_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (node_ch),
    .result (pick_ch),
    .cfg    (cfg_ch)
  );

  best_fit_socket_core_pick_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .item        (node_ch),
    .result      (pick_ch),
    .cfg         (cfg_ch),
    .errors      (errors),
    .outstanding (outstanding),
    .checked     (checked),
    .short_seen  (short_seen)
  );

  always #10 clk = ~clk;

  // Watchdog: a hung block or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("best_fit_socket_core_pick_tb: errors");
      $finish;
    end
  end

  // Result side: random stall bursts, plus one long hold-off on request so the
  // block's queue fills and the item channel backs up.
  initial begin : result_side
    int holds_done;
    holds_done = 0;
    pick_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (holds_done < hold_asks) begin
        pick_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        holds_done++;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        pick_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        pick_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  function automatic node_item_t make_node(logic [MASK_W-1:0] mask, int sockets, int cores,
                                           int cpus, int threads);
    node_item_t n;
    n.core_mask        = mask;
    n.socket_count     = SOCK_FIELD_W'(sockets);
    n.cores_per_socket = CORE_FIELD_W'(cores);
    n.cpus_wanted      = CPU_W'(cpus);
    n.node_threads     = THR_W'(threads);
    return n;
  endfunction

  // Mostly well-formed nodes with a want near their capacity; one in ten is
  // pure noise over the whole range of every field.
  function automatic node_item_t random_node();
    logic [MASK_W-1:0] a, b, mask;
    int                ns, nc, nt, room, cpus;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    if ($urandom_range(0, 9) == 0)
      return make_node(a, $urandom_range(0, 7), $urandom_range(0, 31),
                       $urandom_range(0, 65535), $urandom_range(0, 255));
    case ($urandom_range(0, 3))
      0: mask = a;
      1: mask = a & b;
      2: mask = a | b;
      default: mask = '1;
    endcase
    ns   = $urandom_range(1, DEF_MAX_SOCKETS);
    nc   = $urandom_range(1, DEF_MAX_CORES);
    nt   = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 4);
    room = ns * nc * nt;
    case ($urandom_range(0, 9))
      0: cpus = 0;
      1: cpus = 1;
      8: cpus = $urandom_range(room, 2 * room);
      9: cpus = $urandom_range(0, 65535);
      default: cpus = $urandom_range(1, room);
    endcase
    if (cpus > 65535) cpus = 65535;
    return make_node(mask, ns, nc, cpus, nt);
  endfunction

  function automatic reg_setting_t setting_for(int idx);
    reg_setting_t st;
    case (idx)
      0: st = '{1'b0, 16'd0,     16'd0};
      1: st = '{1'b1, 16'd0,     16'd0};
      2: st = '{1'b0, 16'd0,     16'd2};
      3: st = '{1'b1, 16'd3,     16'd0};
      4: st = '{1'b1, 16'hffff,  16'hffff};
      5: st = '{1'b0, 16'hffff,  16'd1};
      6: st = '{1'b1, 16'd2,     16'd4};
      7: st = '{1'b0, 16'd1,     16'd0};
      default: st = '{1'b1, CAP_W'($urandom_range(0, 6)), CAP_W'($urandom_range(0, 6))};
    endcase
    return st;
  endfunction

  // Leave valid high on return; the next offer replaces the item, an idle stretch or drain drops it.
  task automatic offer_node(input node_item_t n);
    node_ch.valid            <= 1'b1;
    node_ch.core_mask        <= n.core_mask;
    node_ch.socket_count     <= n.socket_count;
    node_ch.cores_per_socket <= n.cores_per_socket;
    node_ch.cpus_wanted      <= n.cpus_wanted;
    node_ch.node_threads     <= n.node_threads;
    @(posedge clk);
    while (!node_ch.ready) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CAP_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  // Stop offering and hold until every predicted result has come back.
  task automatic drain();
    node_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    node_item_t   n;
    reg_setting_t st;
    logic [15:0]  upper;
    rst                      <= 1'b1;
    node_ch.valid            <= 1'b0;
    node_ch.core_mask        <= '0;
    node_ch.socket_count     <= '0;
    node_ch.cores_per_socket <= '0;
    node_ch.cpus_wanted      <= '0;
    node_ch.node_threads     <= '0;
    cfg_ch.valid             <= 1'b0;
    cfg_ch.index             <= REG_COUNT_WHOLE;
    cfg_ch.data              <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed nodes under reset register values.
    offer_node(make_node('1, 4, 16, 0, 1));                       // zero wanted, full node
    offer_node(make_node('1, 7, 31, 65535, 255));                 // geometry saturates, short
    offer_node(make_node('1, 0, 16, 5, 1));                       // no sockets
    offer_node(make_node('1, 4, 0, 1, 1));                        // no cores
    offer_node(make_node('0, 4, 16, 1, 1));                       // empty mask
    offer_node(make_node('0, 4, 16, 0, 0));                       // empty mask, nothing wanted
    offer_node(make_node(64'hffff, 4, 4, 3, 0));                  // zero threads taken as one
    offer_node(make_node('1, 2, 3, 2, 1));                        // bits past the node untouched
    offer_node(make_node(64'h0000_0000_0000_f0f0, 4, 4, 3, 1));   // tie stays on higher socket
    offer_node(make_node(64'h0000_0000_0000_173f, 4, 4, 2, 1));   // smallest that fits
    offer_node(make_node(64'h0000_0000_0000_173f, 4, 4, 9, 1));   // none fits: spill largest first
    offer_node(make_node(64'h0000_0000_0000_00ff, 2, 4, 5, 2));   // last core only half used
    offer_node(make_node(64'h8000_0000_0000_0001, 4, 16, 1, 255));
    offer_node(make_node(64'h5555_aaaa_5555_aaaa, 5, 17, 7, 3));  // both sizes saturate
    offer_node(make_node(64'h1, 1, 1, 1, 1));                     // single core
    offer_node(make_node('1, 4, 16, 64, 1));                      // every core claimed exactly
    offer_node(make_node('1, 4, 16, 65, 1));                      // one cpu too many

    for (int p = 0; p < NUM_SETTINGS; p++) begin
      // Registers change only with the block drained.
      drain();
      repeat (SETTLE_CYCLES) @(posedge clk);
      st    = setting_for(p);
      upper = 16'($urandom) & 16'hfffe;
      write_reg(REG_COUNT_WHOLE, upper | {15'd0, st.whole_cores});
      write_reg(REG_TASK_CAP, st.task_cap);
      write_reg(REG_THREAD_CAP, st.thread_cap);
      cfg_ch.valid <= 1'b0;

      for (int i = 0; i < NODES_PER_SET; i++) begin
        if (p == NUM_SETTINGS - 1 && i == 100) quiet = 1'b1;
        if (p == 3 && i == 60) hold_asks++;
        if (p == 5 && i == 80) drain();
        // Odd settings idle rarely, giving long back-to-back stretches.
        if (!quiet && $urandom_range(0, (p % 2) ? 11 : 3) == 0) begin
          node_ch.valid <= 1'b0;
          repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        n = random_node();
        offer_node(n);
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("best_fit_socket_core_pick_tb summary: %0d node results checked over %0d settings",
             checked, NUM_SETTINGS + 1);
    $display("best_fit_socket_core_pick_tb summary: %0d nodes short of cores, %0d mismatches",
             short_seen, errors);
    if (errors == 0 && outstanding == 0) begin
      $display("best_fit_socket_core_pick_tb: clean");
    end else begin
      $display("best_fit_socket_core_pick_tb: errors");
    end
    $finish;
  end

endmodule
